/* rtl/cpwm_pkg.sv */
// ----------------------------------------------------------------------------
// cpwm_pkg
// Shared constants, command and register codes, and the command decoder
// for the center-aligned complementary PWM block.
// ----------------------------------------------------------------------------
package cpwm_pkg;

    localparam int COUNT_BITS_DEF     = 16;
    localparam int DEAD_BITS_DEF      = 8;
    localparam int DUTY_FRAC_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int HALF_PERIOD_RESET = 600;
    localparam int DEAD_TIME_RESET   = 5;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_SET   = 3'd1,
        CMD_STEP  = 3'd2,
        CMD_START = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HALF_PERIOD = 3'd0,
        REG_DEAD_TIME   = 3'd1,
        REG_DUTY_MIN    = 3'd2,
        REG_DUTY_MAX    = 3'd3
    } cfg_reg_t;

    // Per-word actions handed to the state core.
    typedef struct packed {
        logic tick;
        logic load_set;
        logic load_step;
        logic bridge_on;
        logic bridge_off;
    } op_ctrl_t;

    function automatic op_ctrl_t decode_cmd(input logic [2:0] cmd);
        op_ctrl_t ctrl;
        ctrl = '0;
        case (cmd_t'(cmd))
            CMD_TICK:  ctrl.tick = 1'b1;
            CMD_SET:   ctrl.load_set = 1'b1;
            CMD_STEP:  ctrl.load_step = 1'b1;
            CMD_START: begin
                ctrl.load_set  = 1'b1;
                ctrl.bridge_on = 1'b1;
            end
            CMD_STOP:  ctrl.bridge_off = 1'b1;
            default:   ctrl = '0;
        endcase
        return ctrl;
    endfunction

endpackage

/* rtl/cpwm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cpwm_cfg_regs
// Configuration registers, plus registered duty limits converted to counts.
// ----------------------------------------------------------------------------
module cpwm_cfg_regs #(
    parameter int COUNT_BITS     = cpwm_pkg::COUNT_BITS_DEF,
    parameter int DEAD_BITS      = cpwm_pkg::DEAD_BITS_DEF,
    parameter int DUTY_FRAC_BITS = cpwm_pkg::DUTY_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cpwm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpwm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output logic [COUNT_BITS-1:0]            half_period,
    output logic [DEAD_BITS-1:0]             dead_time,
    output logic [DUTY_FRAC_BITS-1:0]        duty_min,
    output logic [DUTY_FRAC_BITS-1:0]        duty_max,
    output logic [COUNT_BITS-1:0]            min_count,
    output logic [COUNT_BITS-1:0]            max_count
);
    import cpwm_pkg::*;

    localparam int PROD_W = COUNT_BITS + DUTY_FRAC_BITS;

    logic [COUNT_BITS-1:0]     half_period_reg;
    logic [DEAD_BITS-1:0]      dead_time_reg;
    logic [DUTY_FRAC_BITS-1:0] duty_min_reg;
    logic [DUTY_FRAC_BITS-1:0] duty_max_reg;
    logic [COUNT_BITS-1:0]     min_count_reg;
    logic [COUNT_BITS-1:0]     max_count_reg;
    logic [PROD_W-1:0]         min_prod;
    logic [PROD_W-1:0]         max_prod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= COUNT_BITS'(HALF_PERIOD_RESET);
            dead_time_reg   <= DEAD_BITS'(DEAD_TIME_RESET);
            duty_min_reg    <= '0;
            duty_max_reg    <= '1;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_HALF_PERIOD: half_period_reg <= cfg_wdata[COUNT_BITS-1:0];
                REG_DEAD_TIME:   dead_time_reg   <= cfg_wdata[DEAD_BITS-1:0];
                REG_DUTY_MIN:    duty_min_reg    <= cfg_wdata[DUTY_FRAC_BITS-1:0];
                REG_DUTY_MAX:    duty_max_reg    <= cfg_wdata[DUTY_FRAC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Limit counts are registered products of the configuration registers.
    assign min_prod = PROD_W'(half_period_reg) * PROD_W'(duty_min_reg);
    assign max_prod = PROD_W'(half_period_reg) * PROD_W'(duty_max_reg);

    always_ff @(posedge aclk) begin
        min_count_reg <= min_prod[PROD_W-1:DUTY_FRAC_BITS];
        max_count_reg <= max_prod[PROD_W-1:DUTY_FRAC_BITS];
    end

    assign half_period = half_period_reg;
    assign dead_time   = dead_time_reg;
    assign duty_min    = duty_min_reg;
    assign duty_max    = duty_max_reg;
    assign min_count   = min_count_reg;
    assign max_count   = max_count_reg;

endmodule

/* rtl/cpwm_duty_calc.sv */
// ----------------------------------------------------------------------------
// cpwm_duty_calc
// Turns a set or step request into new high and low compare values.
// ----------------------------------------------------------------------------
module cpwm_duty_calc #(
    parameter int COUNT_BITS     = cpwm_pkg::COUNT_BITS_DEF,
    parameter int DEAD_BITS      = cpwm_pkg::DEAD_BITS_DEF,
    parameter int DUTY_FRAC_BITS = cpwm_pkg::DUTY_FRAC_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0]        half_period,
    input  logic [DEAD_BITS-1:0]         dead_time,
    input  logic [DUTY_FRAC_BITS-1:0]    duty_min,
    input  logic [DUTY_FRAC_BITS-1:0]    duty_max,
    input  logic [COUNT_BITS-1:0]        min_count,
    input  logic [COUNT_BITS-1:0]        max_count,
    input  logic [COUNT_BITS-1:0]        high_preload,
    input  logic [DUTY_FRAC_BITS-1:0]    duty_value,
    input  logic signed [COUNT_BITS:0]   step_delta,
    input  logic                         use_step,
    output logic [COUNT_BITS-1:0]        high_load,
    output logic [COUNT_BITS-1:0]        low_load
);
    import cpwm_pkg::*;

    localparam int PROD_W = COUNT_BITS + DUTY_FRAC_BITS;
    localparam int STEP_W = COUNT_BITS + 2;
    localparam int LOW_W  = ((COUNT_BITS > DEAD_BITS) ? COUNT_BITS : DEAD_BITS) + 1;

    logic [DUTY_FRAC_BITS-1:0] target;
    logic [PROD_W-1:0]         prod;
    logic [COUNT_BITS-1:0]     set_count;
    logic signed [STEP_W-1:0]  step_sum;
    logic signed [STEP_W-1:0]  step_lo;
    logic signed [STEP_W-1:0]  step_hi;
    logic [COUNT_BITS-1:0]     step_count;
    logic [LOW_W-1:0]          low_sum;

    always_comb begin
        // Minimum check wins over maximum.
        if (duty_value < duty_min) begin
            target = duty_min;
        end else if (duty_value > duty_max) begin
            target = duty_max;
        end else begin
            target = duty_value;
        end
        prod      = PROD_W'(half_period) * PROD_W'(target);
        set_count = prod[PROD_W-1:DUTY_FRAC_BITS];

        step_sum = $signed({2'b00, high_preload}) + $signed({step_delta[COUNT_BITS], step_delta});
        step_lo  = $signed({2'b00, min_count});
        step_hi  = $signed({2'b00, max_count});
        if (step_sum < step_lo) begin
            step_count = min_count;
        end else if (step_sum > step_hi) begin
            step_count = max_count;
        end else begin
            step_count = step_sum[COUNT_BITS-1:0];
        end

        high_load = use_step ? step_count : set_count;

        // Add dead time, saturate at the counter maximum.
        low_sum = LOW_W'(high_load) + LOW_W'(dead_time);
        if (low_sum > LOW_W'({COUNT_BITS{1'b1}})) begin
            low_load = '1;
        end else begin
            low_load = low_sum[COUNT_BITS-1:0];
        end
    end

endmodule

/* rtl/cpwm_core.sv */
// ----------------------------------------------------------------------------
// cpwm_core
// Up/down counter, preload and active compares, bridge enable, gate drive.
// ----------------------------------------------------------------------------
module cpwm_core #(
    parameter int COUNT_BITS = cpwm_pkg::COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cpwm_pkg::op_ctrl_t    ctrl,
    input  logic [COUNT_BITS-1:0] half_period,
    input  logic [COUNT_BITS-1:0] high_load,
    input  logic [COUNT_BITS-1:0] low_load,
    output logic [COUNT_BITS-1:0] high_preload,
    output logic [COUNT_BITS-1:0] low_preload,
    output logic                  bridge_enabled,
    output logic                  high_side,
    output logic                  low_side
);
    import cpwm_pkg::*;

    logic [COUNT_BITS-1:0] count_reg,       count_next;
    logic                  down_reg,        down_next;
    logic [COUNT_BITS-1:0] high_pre_reg,    high_pre_next;
    logic [COUNT_BITS-1:0] low_pre_reg,     low_pre_next;
    logic [COUNT_BITS-1:0] high_act_reg,    high_act_next;
    logic [COUNT_BITS-1:0] low_act_reg,     low_act_next;
    logic                  enabled_reg,     enabled_next;
    logic [COUNT_BITS-1:0] clipped;
    logic                  turn;

    always_comb begin
        count_next    = count_reg;
        down_next     = down_reg;
        high_pre_next = high_pre_reg;
        low_pre_next  = low_pre_reg;
        high_act_next = high_act_reg;
        low_act_next  = low_act_reg;
        enabled_next  = enabled_reg;
        turn          = 1'b0;
        clipped       = (count_reg > half_period) ? half_period : count_reg;

        if (ctrl.tick) begin
            if (!down_reg) begin
                count_next = (count_reg < half_period) ? count_reg + 1'b1 : half_period;
                turn       = (count_next == half_period);
                down_next  = turn;
            end else begin
                count_next = (clipped != '0) ? clipped - 1'b1 : clipped;
                turn       = (count_next == '0);
                down_next  = !turn;
            end
            if (turn) begin
                high_act_next = high_pre_reg;
                low_act_next  = low_pre_reg;
            end
        end
        if (ctrl.load_set || ctrl.load_step) begin
            high_pre_next = high_load;
            low_pre_next  = low_load;
        end
        if (ctrl.bridge_on) begin
            enabled_next = 1'b1;
        end
        if (ctrl.bridge_off) begin
            enabled_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            down_reg     <= 1'b0;
            high_pre_reg <= '0;
            low_pre_reg  <= '0;
            high_act_reg <= '0;
            low_act_reg  <= '0;
            enabled_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            down_reg     <= down_next;
            high_pre_reg <= high_pre_next;
            low_pre_reg  <= low_pre_next;
            high_act_reg <= high_act_next;
            low_act_reg  <= low_act_next;
            enabled_reg  <= enabled_next;
        end
    end

    assign high_preload   = high_pre_reg;
    assign low_preload    = low_pre_reg;
    assign bridge_enabled = enabled_reg;
    assign high_side      = enabled_reg && (count_reg < high_act_reg);
    assign low_side       = enabled_reg && (count_reg >= low_act_reg);

    a_preload_order: assert property (@(posedge aclk) disable iff (!aresetn)
        low_pre_reg >= high_pre_reg)
        else $error("low preload below high preload");

    a_no_shoot_through: assert property (@(posedge aclk) disable iff (!aresetn)
        !(high_side && low_side))
        else $error("both gates driven at once");

endmodule

/* rtl/center_aligned_pwm_with_deadtime.sv */
// ----------------------------------------------------------------------------
// center_aligned_pwm_with_deadtime
// Flow: the accepting edge loads the input register; the word then moves into
// the state and raises m_valid once the result slot is free or being drained.
// Throughput: one word per cycle; s_ready drops only while a result waits with
// the input register full, or in a cycle that carries a configuration write.
// Reset: synchronous active-low; counter at 0 counting up, compares 0,
// bridge off, config registers at their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module center_aligned_pwm_with_deadtime #(
    parameter int COUNT_BITS     = cpwm_pkg::COUNT_BITS_DEF,
    parameter int DEAD_BITS      = cpwm_pkg::DEAD_BITS_DEF,
    parameter int DUTY_FRAC_BITS = cpwm_pkg::DUTY_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // command words
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_cmd,
    input  logic [DUTY_FRAC_BITS-1:0]        s_duty_value,
    input  logic signed [COUNT_BITS:0]       s_step_delta,

    // result words
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_high_side,
    output logic                             m_low_side,
    output logic [COUNT_BITS-1:0]            m_high_compare_now,
    output logic [COUNT_BITS-1:0]            m_low_compare_now,
    output logic                             m_outputs_on,

    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cpwm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cpwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cpwm_pkg::*;

    // Input word register.
    logic                          in_valid_reg,  in_valid_next;
    logic [2:0]                    cmd_reg;
    logic [DUTY_FRAC_BITS-1:0]     duty_reg;
    logic signed [COUNT_BITS:0]    delta_reg;

    // Result valid; the result payload lives in the core's state registers,
    // which only change when a new result is loaded.
    logic                          out_valid_reg, out_valid_next;

    logic                          advance;
    logic                          s_fire;
    op_ctrl_t                      ctrl;

    logic [COUNT_BITS-1:0]         half_period;
    logic [DEAD_BITS-1:0]          dead_time;
    logic [DUTY_FRAC_BITS-1:0]     duty_min;
    logic [DUTY_FRAC_BITS-1:0]     duty_max;
    logic [COUNT_BITS-1:0]         min_count;
    logic [COUNT_BITS-1:0]         max_count;
    logic [COUNT_BITS-1:0]         high_preload;
    logic [COUNT_BITS-1:0]         low_preload;
    logic [COUNT_BITS-1:0]         high_load;
    logic [COUNT_BITS-1:0]         low_load;

    // Advance the held word into the state once the result slot is free or
    // being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // Hold off commands on a config write edge: the limit counts are registered
    // and lag the new register values.
    assign s_ready = !cfg_valid && (!in_valid_reg || advance);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payload on accept; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= s_cmd;
            duty_reg  <= s_duty_value;
            delta_reg <= s_step_delta;
        end
    end

    // Drop all actions unless the word is moving into the state this cycle.
    assign ctrl = advance ? decode_cmd(cmd_reg) : '0;

    cpwm_cfg_regs #(
        .COUNT_BITS     (COUNT_BITS),
        .DEAD_BITS      (DEAD_BITS),
        .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
    ) u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .half_period (half_period),
        .dead_time   (dead_time),
        .duty_min    (duty_min),
        .duty_max    (duty_max),
        .min_count   (min_count),
        .max_count   (max_count)
    );

    cpwm_duty_calc #(
        .COUNT_BITS     (COUNT_BITS),
        .DEAD_BITS      (DEAD_BITS),
        .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
    ) u_duty (
        .half_period  (half_period),
        .dead_time    (dead_time),
        .duty_min     (duty_min),
        .duty_max     (duty_max),
        .min_count    (min_count),
        .max_count    (max_count),
        .high_preload (high_preload),
        .duty_value   (duty_reg),
        .step_delta   (delta_reg),
        .use_step     (ctrl.load_step),
        .high_load    (high_load),
        .low_load     (low_load)
    );

    cpwm_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .half_period    (half_period),
        .high_load      (high_load),
        .low_load       (low_load),
        .high_preload   (high_preload),
        .low_preload    (low_preload),
        .bridge_enabled (m_outputs_on),
        .high_side      (m_high_side),
        .low_side       (m_low_side)
    );

    assign m_valid            = out_valid_reg;
    assign m_high_compare_now = high_preload;
    assign m_low_compare_now  = low_preload;

    a_gate_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_high_side || m_low_side) |-> m_outputs_on)
        else $error("gate driven while bridge is off");

    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed word produced no result");

    a_held_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(cmd_reg)))
        else $error("stalled input word lost or changed");

endmodule

/* verif/tb_center_aligned_pwm_with_deadtime.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_center_aligned_pwm_with_deadtime
// Self-checking bench for the center-aligned complementary PWM block. Command
// words go in over a valid/ready channel; each is matched against a cycle-free
// behavioral model of the counter, compares and gate drive, or a known directed
// row's typed result. The first part is a short directed table. After it come
// random phases under several register settings, with idle bursts on both
// sides and a long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb_center_aligned_pwm_with_deadtime;
    import cpwm_pkg::*;

    // Command codes the block ignores; they still give a result word.
    localparam logic [2:0] CMD_RSVD_A = 3'd5;
    localparam logic [2:0] CMD_RSVD_B = 3'd6;
    localparam logic [2:0] CMD_RSVD_C = 3'd7;

    localparam int NUM_PHASES  = 10;
    localparam int PHASE_WORDS = 135;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic        high_side;
        logic        low_side;
        logic [15:0] high_cmp;
        logic [15:0] low_cmp;
        logic        bridge_on;
    } pwm_result_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [15:0]        duty;
        logic signed [16:0] delta;
        logic               known;
        pwm_result_t        want;
    } dir_row_t;

    // Directed words, run at reset settings (top 600, dead time 5, full duty
    // range). Rows marked known carry a result that can be read off directly.
    localparam dir_row_t DIR_ROWS [25] = '{
        '{CMD_STOP,   16'h0000,  17'sd0,     1'b1, '{1'b0, 1'b0, 16'd0,   16'd0,   1'b0}},
        '{CMD_TICK,   16'hFFFF, -17'sd1,     1'b1, '{1'b0, 1'b0, 16'd0,   16'd0,   1'b0}},
        '{CMD_SET,    16'h0000,  17'sd0,     1'b1, '{1'b0, 1'b0, 16'd0,   16'd5,   1'b0}},
        '{CMD_SET,    16'hFFFF,  17'sd0,     1'b1, '{1'b0, 1'b0, 16'd599, 16'd604, 1'b0}},
        '{CMD_SET,    16'h8000,  17'sd0,     1'b1, '{1'b0, 1'b0, 16'd300, 16'd305, 1'b0}},
        '{CMD_STEP,   16'h0000,  17'sd65535, 1'b1, '{1'b0, 1'b0, 16'd599, 16'd604, 1'b0}},
        '{CMD_STEP,   16'h0000, -17'sd65535, 1'b1, '{1'b0, 1'b0, 16'd0,   16'd5,   1'b0}},
        '{CMD_STEP,   16'h0000,  17'sd17,    1'b0, '0},
        '{CMD_STEP,   16'hFFFF,  17'sd0,     1'b0, '0},
        '{CMD_RSVD_A, 16'hFFFF, -17'sd1,     1'b0, '0},
        '{CMD_RSVD_B, 16'h0000,  17'sd65535, 1'b0, '0},
        '{CMD_RSVD_C, 16'h5555, -17'sd21845, 1'b0, '0},
        '{CMD_START,  16'h5555,  17'sd0,     1'b0, '0},
        '{CMD_TICK,   16'h0000,  17'sd0,     1'b0, '0},
        '{CMD_TICK,   16'h0000,  17'sd0,     1'b0, '0},
        '{CMD_TICK,   16'h0000,  17'sd0,     1'b0, '0},
        '{CMD_STEP,   16'h0000, -17'sd1,     1'b0, '0},
        '{CMD_SET,    16'hAAAA,  17'sd0,     1'b0, '0},
        '{CMD_STOP,   16'h0000,  17'sd0,     1'b0, '0},
        '{CMD_TICK,   16'h0000,  17'sd0,     1'b0, '0},
        '{CMD_START,  16'hFFFF,  17'sd0,     1'b0, '0},
        '{CMD_START,  16'h0000,  17'sd0,     1'b0, '0},
        '{CMD_TICK,   16'hAAAA,  17'sd21845, 1'b0, '0},
        '{CMD_TICK,   16'h0000,  17'sd0,     1'b0, '0},
        '{CMD_STOP,   16'h0000,  17'sd0,     1'b0, '0}
    };

    // DUT ports: every input starts at a known value
    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_cmd = CMD_TICK;
    logic [15:0]        s_duty_value = '0;
    logic signed [16:0] s_step_delta = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_high_side;
    logic               m_low_side;
    logic [15:0]        m_high_compare_now;
    logic [15:0]        m_low_compare_now;
    logic               m_outputs_on;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_HALF_PERIOD;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    center_aligned_pwm_with_deadtime dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_duty_value       (s_duty_value),
        .s_step_delta       (s_step_delta),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_high_side        (m_high_side),
        .m_low_side         (m_low_side),
        .m_high_compare_now (m_high_compare_now),
        .m_low_compare_now  (m_low_compare_now),
        .m_outputs_on       (m_outputs_on),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata)
    );

    // Model copy of the registers, at their reset values
    logic [15:0] pwm_top    = 16'd600;
    logic [7:0]  pwm_dead   = 8'd5;
    logic [15:0] duty_floor = 16'd0;
    logic [15:0] duty_ceil  = 16'hFFFF;

    // Model copy of the counter, compares and bridge enable
    logic [15:0] ctr        = '0;
    logic        ctr_down   = 1'b0;
    logic [15:0] hi_pre     = '0;
    logic [15:0] lo_pre     = '0;
    logic [15:0] hi_live    = '0;
    logic [15:0] lo_live    = '0;
    logic        bridge_en  = 1'b0;

    pwm_result_t bridge_expect_q[$];

    int mismatch_count = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int reg_writes     = 0;

    bit tx_idle_en   = 1'b0;
    bit rx_idle_en   = 1'b0;
    bit rx_long_hold = 1'b0;
    int rx_stall     = 0;

    // ------------------------------------------------------------------------
    // Behavioral model of the bridge
    // ------------------------------------------------------------------------

    // Q0.16 duty fraction to counter counts at the current top.
    function automatic logic [15:0] duty_counts(input logic [15:0] duty);
        logic [31:0] prod;
        prod = 32'(pwm_top) * 32'(duty);
        return prod[31:16];
    endfunction

    // Load both preloads; the low side adds dead time and saturates.
    function automatic void load_preloads(input logic [15:0] high_cnt);
        logic [16:0] sum;
        sum    = {1'b0, high_cnt} + 17'(pwm_dead);
        hi_pre = high_cnt;
        lo_pre = sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    // Clamp against the minimum first, so a floor above the ceiling wins.
    function automatic void apply_duty(input logic [15:0] duty);
        logic [15:0] target;
        if (duty < duty_floor)
            target = duty_floor;
        else if (duty > duty_ceil)
            target = duty_ceil;
        else
            target = duty;
        load_preloads(duty_counts(target));
    endfunction

    function automatic void apply_step(input logic signed [16:0] delta);
        int sum;
        int lo_lim;
        int hi_lim;
        sum    = int'(hi_pre) + int'(delta);
        lo_lim = int'(duty_counts(duty_floor));
        hi_lim = int'(duty_counts(duty_ceil));
        if (sum < lo_lim)
            sum = lo_lim;
        else if (sum > hi_lim)
            sum = hi_lim;
        load_preloads(sum[15:0]);
    endfunction

    // One counter step; preloads go live at the top and at zero. A counter
    // left above a lowered top snaps to the top.
    function automatic void advance_counter();
        bit turn;
        turn = 1'b0;
        if (!ctr_down) begin
            if (ctr < pwm_top)
                ctr = ctr + 16'd1;
            else
                ctr = pwm_top;
            if (ctr >= pwm_top) begin
                ctr_down = 1'b1;
                turn     = 1'b1;
            end
        end else begin
            if (ctr > pwm_top)
                ctr = pwm_top;
            if (ctr > 0)
                ctr = ctr - 16'd1;
            if (ctr == 0) begin
                ctr_down = 1'b0;
                turn     = 1'b1;
            end
        end
        if (turn) begin
            hi_live = hi_pre;
            lo_live = lo_pre;
        end
    endfunction

    // Apply one command word to the model and return the gate state after it.
    function automatic pwm_result_t bridge_response(input logic [2:0] cmd,
                                                    input logic [15:0] duty,
                                                    input logic signed [16:0] delta);
        pwm_result_t res;
        case (cmd)
            CMD_TICK:  advance_counter();
            CMD_SET:   apply_duty(duty);
            CMD_STEP:  apply_step(delta);
            CMD_START: begin
                apply_duty(duty);
                bridge_en = 1'b1;
            end
            CMD_STOP:  bridge_en = 1'b0;
            default:   ;
        endcase
        res.high_side = bridge_en && (ctr < hi_live);
        res.low_side  = bridge_en && (ctr >= lo_live);
        res.high_cmp  = hi_pre;
        res.low_cmp   = lo_pre;
        res.bridge_on = bridge_en;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reporting
    // ------------------------------------------------------------------------
    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        mismatch_count++;
        // keep the log short if the block is badly off
        if (mismatch_count <= 30)
            $display("ERROR: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Result side: check every accepted word, then drive ready for the next
    // edge. Idle bursts are drawn at random; a long hold is requested by the
    // stimulus and counted down here.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_side
        pwm_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (bridge_expect_q.size() == 0) begin
                report_error($sformatf("result word %0d arrived with nothing expected",
                                       results_seen));
            end else begin
                want = bridge_expect_q.pop_front();
                if (m_high_side !== want.high_side)
                    report_error($sformatf("word %0d high_side %b, expected %b",
                                           results_seen, m_high_side, want.high_side));
                if (m_low_side !== want.low_side)
                    report_error($sformatf("word %0d low_side %b, expected %b",
                                           results_seen, m_low_side, want.low_side));
                if (m_high_compare_now !== want.high_cmp)
                    report_error($sformatf("word %0d high_compare_now %0d, expected %0d",
                                           results_seen, m_high_compare_now, want.high_cmp));
                if (m_low_compare_now !== want.low_cmp)
                    report_error($sformatf("word %0d low_compare_now %0d, expected %0d",
                                           results_seen, m_low_compare_now, want.low_cmp));
                if (m_outputs_on !== want.bridge_on)
                    report_error($sformatf("word %0d outputs_on %b, expected %b",
                                           results_seen, m_outputs_on, want.bridge_on));
            end
        end

        if (rx_long_hold) begin
            rx_stall     = HOLD_CYCLES;
            rx_long_hold = 1'b0;
        end
        if (rx_stall > 0) begin
            m_ready <= 1'b0;
            rx_stall--;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            // idle burst that starts in this cycle
            m_ready  <= 1'b0;
            rx_stall = $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Offer one word and hold it until accepted; predict on acceptance.
    // A known row pushes its typed result instead of the model's.
    task automatic send_word(input logic [2:0] cmd, input logic [15:0] duty,
                             input logic signed [16:0] delta,
                             input bit known, input pwm_result_t typed_res);
        pwm_result_t res;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_duty_value <= duty;
        s_step_delta <= delta;
        do @(posedge aclk); while (s_ready !== 1'b1);
        res = bridge_response(cmd, duty, delta);
        bridge_expect_q.push_back(known ? typed_res : res);
        words_sent++;
    endtask

    // Ticks dominate so that the counter actually turns; the rest mixes in
    // duty changes, bridge on/off and the ignored codes.
    task automatic send_random_word();
        logic [2:0]         cmd;
        logic [15:0]        duty;
        logic signed [16:0] delta;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)      cmd = CMD_TICK;
        else if (pick < 70) cmd = CMD_SET;
        else if (pick < 82) cmd = CMD_STEP;
        else if (pick < 90) cmd = CMD_START;
        else if (pick < 96) cmd = CMD_STOP;
        else                cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));

        case ($urandom_range(0, 7))
            0:       duty = 16'h0000;
            1:       duty = 16'hFFFF;
            default: duty = 16'($urandom);
        endcase

        case ($urandom_range(0, 9))
            0:          delta = -17'sd65535;
            1:          delta = 17'sd65535;
            2, 3, 4:    delta = 17'(int'($urandom_range(0, 131070)) - 65535);
            default:    delta = 17'(int'($urandom_range(0, 16)) - 8);
        endcase

        send_word(cmd, duty, delta, 1'b0, '0);
    endtask

    // Hold off until every expected word is back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (bridge_expect_q.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_HALF_PERIOD: pwm_top    = val;
            REG_DEAD_TIME:   pwm_dead   = val[7:0];
            REG_DUTY_MIN:    duty_floor = val;
            REG_DUTY_MAX:    duty_ceil  = val;
            default:         ;
        endcase
        reg_writes++;
    endtask

    // Program all four registers with the block idle.
    task automatic program_regs(input logic [15:0] top, input logic [7:0] dead,
                                input logic [15:0] dmin, input logic [15:0] dmax);
        wait_drained();
        write_reg(REG_HALF_PERIOD, top);
        write_reg(REG_DEAD_TIME, 16'(dead));
        write_reg(REG_DUTY_MIN, dmin);
        write_reg(REG_DUTY_MAX, dmax);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int phase;
        int k;
        int n_words;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // Directed part at reset settings
        foreach (DIR_ROWS[i])
            send_word(DIR_ROWS[i].cmd, DIR_ROWS[i].duty, DIR_ROWS[i].delta,
                      DIR_ROWS[i].known, DIR_ROWS[i].want);

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            n_words = PHASE_WORDS;
            case (phase)
                0: program_regs(16'd20, 8'd3, 16'd0, 16'hFFFF);
                1: program_regs(16'd1, 8'd0, 16'd0, 16'hFFFF);
                // widest top, widest dead time: low compare saturates
                2: begin
                    program_regs(16'hFFFF, 8'd255, 16'd0, 16'hFFFF);
                    n_words = 60;
                end
                // drop the top under a counter that has run far up
                3: program_regs(16'd9, 8'd1, 16'd0, 16'hFFFF);
                // floor above ceiling
                4: program_regs(16'd30, 8'd2, 16'd50000, 16'd10000);
                5: program_regs(16'd12, 8'd7, 16'hFFFF, 16'd0);
                9: begin
                    program_regs(16'($urandom_range(3, 48)), 8'($urandom_range(0, 255)),
                                 16'd0, 16'hFFFF);
                    // last stretch runs with no idling on either side
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                default: program_regs(16'($urandom_range(2, 64)), 8'($urandom_range(0, 255)),
                                      16'($urandom_range(0, 30000)),
                                      16'($urandom_range(35000, 65535)));
            endcase

            if (phase == 0) begin
                // Stall the result side for a long stretch and keep offering
                // words back to back so the block backs up its input.
                rx_long_hold = 1'b1;
                tx_idle_en   = 1'b0;
                for (k = 0; k < 40; k++)
                    send_random_word();
                tx_idle_en = 1'b1;
            end

            for (k = 0; k < n_words; k++) begin
                send_random_word();
                // one mid-phase pause until everything is back
                if (phase == 0 && k == 60)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Summary: %0d command words over the directed table and %0d register settings,",
                 words_sent, NUM_PHASES);
        $display("Summary: %0d result words checked, %0d register writes, %0d mismatches.",
                 results_seen, reg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("center_aligned_pwm_with_deadtime test passed");
        end else begin
            $display("center_aligned_pwm_with_deadtime test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout: %0d words sent, %0d results seen", words_sent, results_seen);
        $display("center_aligned_pwm_with_deadtime test failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/cpwm_pkg.sv
rtl/cpwm_cfg_regs.sv
rtl/cpwm_duty_calc.sv
rtl/cpwm_core.sv
rtl/center_aligned_pwm_with_deadtime.sv
verif/tb_center_aligned_pwm_with_deadtime.sv
